// File: rtl/tpp_pkg.sv
// tpp_pkg: shared types and constants for the timed path playback interpolator
// no dependencies
`timescale 1ns / 1ps
package tpp_pkg;
    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_BITS_DEF = 12;
    localparam int TIME_BITS      = 32;
    localparam int CNT_BITS       = 11;
    localparam int FRAC_BITS      = 16;

    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_STOP   = 2'd2,
        REQ_QUERY  = 2'd3
    } t_req;

    typedef struct packed {
        logic [1:0]                req_type;
        logic [COORD_BITS_DEF-1:0] coord_x;
        logic [COORD_BITS_DEF-1:0] coord_y;
        logic [TIME_BITS-1:0]      time_value;
    } t_in_item;

    typedef struct packed {
        logic [COORD_BITS_DEF-1:0] pos_x;
        logic [COORD_BITS_DEF-1:0] pos_y;
        logic                      pos_valid;
        logic [CNT_BITS-1:0]       stored_points;
        logic                      point_dropped;
    } t_out_item;
endpackage

// File: rtl/tpp_divider.sv
// tpp_divider: bit-serial unsigned divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps
module tpp_divider #(
    parameter int NUM_BITS = 48,
    parameter int DEN_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_quo,
    output logic [DEN_BITS-1:0] o_rem
);
    localparam int CB = $clog2(NUM_BITS + 1);
    logic [NUM_BITS-1:0] r_quo;
    logic [DEN_BITS:0]   r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [CB-1:0]       r_cnt;
    logic                r_busy, r_done;
    logic [DEN_BITS:0]   w_sh;

    assign w_sh = {r_rem[DEN_BITS-1:0], r_quo[NUM_BITS-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= CB'(NUM_BITS);
            end else if (r_busy) begin
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem <= w_sh - {1'b0, r_den};
                    r_quo <= {r_quo[NUM_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_quo <= {r_quo[NUM_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CB'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[DEN_BITS-1:0];
endmodule

// File: rtl/tpp_point_mem.sv
// tpp_point_mem: point table, x, y and relative time, one write and one read port
// depends on tpp_pkg
`timescale 1ns / 1ps
module tpp_point_mem #(
    parameter int MAX_POINTS = tpp_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = tpp_pkg::COORD_BITS_DEF,
    parameter int AW = $clog2(MAX_POINTS)
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [AW-1:0]                  i_waddr,
    input  logic [2*COORD_BITS+31:0]       i_wdata,
    input  logic [AW-1:0]                  i_raddr,
    output logic [2*COORD_BITS+31:0]       o_rdata
);
    logic [2*COORD_BITS+31:0] r_mem [MAX_POINTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/timed_path_playback_interpolator_unit.sv
// timed_path_playback_interpolator_unit: records timestamped points, plays back by lerp
// start, append and stop go to S_DONE, which registers the strobe; a query reads the last
// row, wraps its time with the 32-step divider when it is past the end, scans the rows,
// reads the hit segment, divides, multiplies and sums; a query without a position ends early
// one item at a time, busy drops in the cycle the result is strobed; receiver cannot stall
// synchronous active-low reset clears count, recording flag and start time
`timescale 1ns / 1ps
module timed_path_playback_interpolator_unit #(
    parameter int MAX_POINTS = tpp_pkg::MAX_POINTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  tpp_pkg::t_in_item   i_item,
    output logic                o_strobe,
    output tpp_pkg::t_out_item  o_item
);
    localparam int COORD_BITS = tpp_pkg::COORD_BITS_DEF;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = tpp_pkg::CNT_BITS;
    localparam int TW = tpp_pkg::TIME_BITS;
    localparam int FB = tpp_pkg::FRAC_BITS;
    localparam int DW = 2 * COORD_BITS + TW;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_LAST, S_WAIT_LAST, S_WRAP, S_WRAP_WAIT, S_SCAN_RD, S_SCAN_CHK,
        S_HIT_RD, S_HIT_WAIT, S_DIV, S_DIV_WAIT, S_MUL, S_SUM, S_DONE
    } t_state;

    t_state                 r_state;
    logic [CW-1:0]          r_count;
    logic                   r_rec;
    logic [TW-1:0]          r_t0;
    logic [TW-1:0]          r_t, r_total;
    logic [COORD_BITS-1:0]  r_lx, r_ly, r_ax, r_ay, r_bx, r_by;
    logic [TW-1:0]          r_ta, r_prev_t;
    logic [AW:0]            r_idx;
    logic [AW:0]            r_hit;
    logic                   r_found;
    logic [FB:0]            r_frac;
    logic [COORD_BITS+FB:0] r_pa, r_pb, r_qa, r_qb;
    logic                   r_strobe;
    tpp_pkg::t_out_item     r_out;

    logic                   w_we;
    logic [AW-1:0]          w_waddr, w_raddr;
    logic [DW-1:0]          w_wdata, w_rdata;
    logic [AW-1:0]          r_raddr;
    logic [COORD_BITS-1:0]  w_rx, w_ry;
    logic [TW-1:0]          w_rt;

    logic                   r_wgo, r_fgo;
    logic                   w_wdone, w_fdone;
    logic [TW-1:0]          w_wquo_unused_hi;
    logic [TW-1:0]          w_wrem;
    logic [TW+FB-1:0]       w_fquo;
    logic [TW-1:0]          w_frem;
    logic [TW-1:0]          w_wq;
    logic [TW+FB-1:0]       w_fq_unused;

    assign w_rx = w_rdata[DW-1 -: COORD_BITS];
    assign w_ry = w_rdata[TW +: COORD_BITS];
    assign w_rt = w_rdata[TW-1:0];
    assign w_raddr = r_raddr;
    assign w_wquo_unused_hi = w_wq;
    assign w_fq_unused = w_fquo;

    tpp_point_mem #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS), .AW(AW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    tpp_divider #(.NUM_BITS(TW), .DEN_BITS(TW)) u_wrap (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_wgo),
        .i_num(r_t), .i_den(r_total),
        .o_done(w_wdone), .o_quo(w_wq), .o_rem(w_wrem)
    );

    tpp_divider #(.NUM_BITS(TW + FB), .DEN_BITS(TW)) u_frac (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_fgo),
        .i_num({r_t - r_ta, {FB{1'b0}}}), .i_den(w_rt - r_ta),
        .o_done(w_fdone), .o_quo(w_fquo), .o_rem(w_frem)
    );

    // write port used only by start and append in the idle accept cycle
    logic w_acc, w_full;
    assign w_acc  = start && (r_state == S_IDLE);
    assign w_full = (r_count >= CW'(MAX_POINTS));
    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = {i_item.coord_x[COORD_BITS-1:0], i_item.coord_y[COORD_BITS-1:0],
                   i_item.time_value - r_t0};
        if (w_acc) begin
            unique case (i_item.req_type)
                tpp_pkg::REQ_START: begin
                    w_we    = 1'b1;
                    w_wdata = {i_item.coord_x[COORD_BITS-1:0],
                               i_item.coord_y[COORD_BITS-1:0], {TW{1'b0}}};
                end
                tpp_pkg::REQ_APPEND: begin
                    w_we    = !w_full;
                    w_waddr = r_count[AW-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rec    <= 1'b0;
            r_t0     <= '0;
            r_strobe <= 1'b0;
            r_wgo    <= 1'b0;
            r_fgo    <= 1'b0;
            r_frac   <= '0;
        end else begin
            r_strobe <= 1'b0;
            r_wgo    <= 1'b0;
            r_fgo    <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_out <= '0;
                        unique case (i_item.req_type)
                            tpp_pkg::REQ_START: begin
                                r_rec   <= 1'b1;
                                r_t0    <= i_item.time_value;
                                r_count <= CW'(1);
                                r_out.stored_points <= CW'(1);
                                r_state <= S_DONE;
                            end
                            tpp_pkg::REQ_APPEND: begin
                                r_out.point_dropped <= w_full;
                                r_count <= w_full ? r_count : r_count + 1'b1;
                                r_out.stored_points <= w_full ? r_count : r_count + 1'b1;
                                r_state <= S_DONE;
                            end
                            tpp_pkg::REQ_STOP: begin
                                r_rec   <= 1'b0;
                                r_out.stored_points <= r_count;
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_out.stored_points <= r_count;
                                r_t     <= i_item.time_value;
                                r_raddr <= AW'(r_count - 1'b1);
                                r_state <= (r_rec || r_count < CW'(2)) ? S_DONE : S_RD_LAST;
                            end
                        endcase
                    end
                end
                S_RD_LAST: r_state <= S_WAIT_LAST;
                S_WAIT_LAST: begin
                    r_total <= w_rt;
                    r_lx    <= w_rx;
                    r_ly    <= w_ry;
                    if (w_rt == '0) begin
                        r_state <= S_DONE;
                    end else if (r_t > w_rt) begin
                        r_wgo   <= 1'b1;
                        r_state <= S_WRAP;
                    end else begin
                        r_state <= S_WRAP_WAIT;
                    end
                end
                S_WRAP: begin
                    if (w_wdone) begin
                        r_t     <= (w_wrem == '0) ? r_total : w_wrem;
                        r_state <= S_WRAP_WAIT;
                    end
                end
                S_WRAP_WAIT: begin
                    if (r_t == r_total) begin
                        r_out.pos_x     <= r_lx;
                        r_out.pos_y     <= r_ly;
                        r_out.pos_valid <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_found <= 1'b0;
                        r_idx   <= '0;
                        r_raddr <= '0;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN_CHK;
                S_SCAN_CHK: begin
                    // row r_idx now read; check segment r_idx-1
                    if (r_idx != '0 && r_t >= r_prev_t && r_t < w_rt) begin
                        r_found <= 1'b1;
                        r_hit   <= r_idx - 1'b1;
                    end
                    r_prev_t <= w_rt;
                    if ((r_idx + 1'b1) >= (AW+1)'(r_count)) begin
                        r_state <= S_HIT_RD;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_raddr <= AW'(r_idx + 1'b1);
                        r_state <= S_SCAN_RD;
                    end
                end
                S_HIT_RD: begin
                    if (!r_found) begin
                        r_state <= S_DONE;
                    end else begin
                        r_raddr <= r_hit[AW-1:0];
                        r_state <= S_HIT_WAIT;
                    end
                end
                S_HIT_WAIT: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_ax    <= w_rx;
                    r_ay    <= w_ry;
                    r_ta    <= w_rt;
                    r_raddr <= AW'(r_hit + 1'b1);
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (!r_fgo && !w_fdone && r_frac != {1'b1, {FB{1'b0}}}) begin
                        r_fgo   <= 1'b1;
                        r_frac  <= {1'b1, {FB{1'b0}}};
                    end else if (w_fdone) begin
                        r_bx    <= w_rx;
                        r_by    <= w_ry;
                        r_frac  <= {1'b0, w_fquo[FB-1:0]};
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_pa <= (COORD_BITS+FB+1)'(r_ax) * ((FB+1)'(1 << FB) - r_frac);
                    r_pb <= (COORD_BITS+FB+1)'(r_bx) * r_frac;
                    r_qa <= (COORD_BITS+FB+1)'(r_ay) * ((FB+1)'(1 << FB) - r_frac);
                    r_qb <= (COORD_BITS+FB+1)'(r_by) * r_frac;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_out.pos_x <= COORD_BITS'((r_pa + r_pb
                                   + (COORD_BITS+FB+1)'(1 << (FB-1))) >> FB);
                    r_out.pos_y <= COORD_BITS'((r_qa + r_qb
                                   + (COORD_BITS+FB+1)'(1 << (FB-1))) >> FB);
                    r_out.pos_valid <= 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_frac   <= '0;
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic w_unused;
    assign w_unused = ^{w_frem, w_fq_unused[TW+FB-1:FB], w_wquo_unused_hi};

    assign busy     = (r_state != S_IDLE) || w_unused & 1'b0;
    assign o_strobe = r_strobe;
    assign o_item   = r_out;
endmodule
